// File: sv/tsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_pkg: shared types, constants and microcode for the sliver filter
// Holds the word formats, the command and status groups between the
// controller and the datapath, and the multiply-accumulate program.
// ----------------------------------------------------------------------------
package tsf_pkg;

    localparam int COORD_W   = 20;
    localparam int VTX_AW    = 10;
    localparam int VTX_DEPTH = 1 << VTX_AW;
    localparam int FILL_W    = VTX_AW + 1;
    localparam int EMIT_W    = 13;
    localparam int MAX_OUT   = 4096;
    localparam int CNT_W     = 12;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int OPND_W    = 29;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = 102;
    localparam int MAG_W     = 2 * DIFF_W;
    localparam int HALF_W    = DIFF_W;
    localparam int AREA_W    = 88;
    localparam int ESQ_W     = 84;
    localparam int RHS_W     = 100;
    localparam int CHUNK_W   = 28;
    localparam int RATIO_W   = 16;
    localparam int STEP_W    = 5;
    localparam int SHIFT_W   = 6;
    localparam int SEQ_W     = 6;
    localparam int LAST_STEP = 30;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SUBMIT = 2'd2,
        OP_UNUSED = 2'd3
    } t_op_code;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_KEPT       = 3'd1,
        ST_DEGENERATE = 3'd2,
        ST_THIN       = 3'd3,
        ST_BAD_INDEX  = 3'd4,
        ST_CAPACITY   = 3'd5,
        ST_IGNORED    = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        V_NONE = 2'd0,
        V_A    = 2'd1,
        V_B    = 2'd2,
        V_C    = 2'd3
    } t_vsel;

    typedef enum logic [4:0] {
        S_ZERO, S_UX, S_UY, S_UZ, S_VX, S_VY, S_VZ, S_WX, S_WY, S_WZ,
        S_CXH, S_CXL, S_CYH, S_CYL, S_CZH, S_CZL, S_EH, S_EL,
        S_Q0, S_Q1, S_Q2, S_RATIO
    } t_src;

    typedef enum logic [3:0] {
        D_NONE, D_CX, D_CY, D_CZ, D_E0, D_E1, D_E2, D_AREA, D_ESQ, D_RHS
    } t_dst;

    typedef struct packed {
        t_src               a;
        t_src               b;
        logic               neg;
        logic [SHIFT_W-1:0] shift;
        t_dst               dst;
    } t_uop;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [VTX_AW-1:0]       index_a;
        logic [VTX_AW-1:0]       index_b;
        logic [VTX_AW-1:0]       index_c;
    } t_in;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                    run_last;
        logic [CNT_W-1:0]        triangles_seen;
        logic [CNT_W-1:0]        degenerate_count;
        logic [CNT_W-1:0]        thin_count;
        logic [CNT_W-1:0]        kept_count;
    } t_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vertex;

    typedef struct packed {
        logic              latch_in;
        logic              clear_mesh;
        logic              append;
        logic              inc_seen;
        logic              set_error;
        logic              rd_en;
        t_vsel             rd_sel;
        logic              diff_en;
        logic              mac_en;
        logic [STEP_W-1:0] step;
        logic              inc_degen;
        logic              inc_thin;
        logic              inc_kept;
        logic              load_out;
        t_status           out_status;
        t_vsel             out_vsel;
        logic              out_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       err;
        logic       fill_full;
        logic       idx_bad;
        logic       room_ok;
        logic       degen;
        logic       thin;
        logic       out_free;
    } t_stat;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic t_uop mk(input t_src a, input t_src b, input logic neg,
                                input logic [SHIFT_W-1:0] shift, input t_dst dst);
        t_uop u;
        u.a     = a;
        u.b     = b;
        u.neg   = neg;
        u.shift = shift;
        u.dst   = dst;
        return u;
    endfunction

    // Multiply-accumulate program. Cross products first, then the edge
    // lengths, the squared area, the squared longest edge and the bound.
    function automatic t_uop uop(input logic [STEP_W-1:0] step);
        t_uop u;
        u = mk(S_ZERO, S_ZERO, 1'b0, 6'd0, D_NONE);
        case (step)
            5'd0:  u = mk(S_UY, S_VZ, 1'b0, 6'd0, D_NONE);
            5'd1:  u = mk(S_UZ, S_VY, 1'b1, 6'd0, D_CX);
            5'd2:  u = mk(S_UZ, S_VX, 1'b0, 6'd0, D_NONE);
            5'd3:  u = mk(S_UX, S_VZ, 1'b1, 6'd0, D_CY);
            5'd4:  u = mk(S_UX, S_VY, 1'b0, 6'd0, D_NONE);
            5'd5:  u = mk(S_UY, S_VX, 1'b1, 6'd0, D_CZ);
            5'd6:  u = mk(S_UX, S_UX, 1'b0, 6'd0, D_NONE);
            5'd7:  u = mk(S_UY, S_UY, 1'b0, 6'd0, D_NONE);
            5'd8:  u = mk(S_UZ, S_UZ, 1'b0, 6'd0, D_E0);
            5'd9:  u = mk(S_WX, S_WX, 1'b0, 6'd0, D_NONE);
            5'd10: u = mk(S_WY, S_WY, 1'b0, 6'd0, D_NONE);
            5'd11: u = mk(S_WZ, S_WZ, 1'b0, 6'd0, D_E1);
            5'd12: u = mk(S_VX, S_VX, 1'b0, 6'd0, D_NONE);
            5'd13: u = mk(S_VY, S_VY, 1'b0, 6'd0, D_NONE);
            5'd14: u = mk(S_VZ, S_VZ, 1'b0, 6'd0, D_E2);
            5'd15: u = mk(S_CXH, S_CXH, 1'b0, 6'd42, D_NONE);
            5'd16: u = mk(S_CXH, S_CXL, 1'b0, 6'd22, D_NONE);
            5'd17: u = mk(S_CXL, S_CXL, 1'b0, 6'd0, D_NONE);
            5'd18: u = mk(S_CYH, S_CYH, 1'b0, 6'd42, D_NONE);
            5'd19: u = mk(S_CYH, S_CYL, 1'b0, 6'd22, D_NONE);
            5'd20: u = mk(S_CYL, S_CYL, 1'b0, 6'd0, D_NONE);
            5'd21: u = mk(S_CZH, S_CZH, 1'b0, 6'd42, D_NONE);
            5'd22: u = mk(S_CZH, S_CZL, 1'b0, 6'd22, D_NONE);
            5'd23: u = mk(S_CZL, S_CZL, 1'b0, 6'd0, D_AREA);
            5'd24: u = mk(S_EH, S_EH, 1'b0, 6'd42, D_NONE);
            5'd25: u = mk(S_EH, S_EL, 1'b0, 6'd22, D_NONE);
            5'd26: u = mk(S_EL, S_EL, 1'b0, 6'd0, D_ESQ);
            5'd28: u = mk(S_Q0, S_RATIO, 1'b0, 6'd0, D_NONE);
            5'd29: u = mk(S_Q1, S_RATIO, 1'b0, 6'd28, D_NONE);
            5'd30: u = mk(S_Q2, S_RATIO, 1'b0, 6'd56, D_RHS);
            default: u = mk(S_ZERO, S_ZERO, 1'b0, 6'd0, D_NONE);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: sv/tsf_vstore.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_vstore: vertex position memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsf_vstore (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [tsf_pkg::VTX_AW-1:0]    i_waddr,
    input  wire tsf_pkg::t_vertex              i_wdata,
    input  wire logic                          i_re,
    input  wire logic [tsf_pkg::VTX_AW-1:0]    i_raddr,
    output tsf_pkg::t_vertex                   o_rdata
);

    tsf_pkg::t_vertex r_mem [tsf_pkg::VTX_DEPTH];
    tsf_pkg::t_vertex r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule
`default_nettype wire

// File: sv/tsf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_datapath: vertex store, shared multiplier, counters and result register
// Executes the commands of the controller and reports status back.
// ----------------------------------------------------------------------------
module tsf_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tsf_pkg::t_in                  i_in,
    input  wire logic                          i_cfg_we,
    input  wire logic [tsf_pkg::RATIO_W-1:0]   i_cfg_data,
    input  wire tsf_pkg::t_cmd                 i_cmd,
    output tsf_pkg::t_stat                     o_stat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output tsf_pkg::t_out                      o_out
);

    tsf_pkg::t_in                       r_in;
    logic [tsf_pkg::RATIO_W-1:0]        r_ratio;
    logic [tsf_pkg::FILL_W-1:0]         r_fill, n_fill;
    logic [tsf_pkg::EMIT_W-1:0]         r_emitted, n_emitted;
    logic [tsf_pkg::CNT_W-1:0]          r_seen, n_seen, r_degen, n_degen;
    logic [tsf_pkg::CNT_W-1:0]          r_thin, n_thin, r_kept, n_kept;
    logic                               r_error, n_error;
    logic                               r_out_valid;
    tsf_pkg::t_out                      r_out;

    logic                               r_rd_pend;
    tsf_pkg::t_vsel                     r_rd_slot;
    logic [tsf_pkg::VTX_AW-1:0]         rd_addr;
    tsf_pkg::t_vertex                   rd_data, wr_data;
    tsf_pkg::t_vertex                   r_va, r_vb, r_vc;

    logic signed [tsf_pkg::DIFF_W-1:0]  r_du [3];
    logic signed [tsf_pkg::DIFF_W-1:0]  r_dv [3];
    logic signed [tsf_pkg::DIFF_W-1:0]  r_dw [3];
    logic [tsf_pkg::MAG_W-1:0]          r_cr [3];
    logic [tsf_pkg::MAG_W-1:0]          r_e [3];
    logic [tsf_pkg::MAG_W-1:0]          r_emax;
    logic [tsf_pkg::AREA_W-1:0]         r_area;
    logic [tsf_pkg::ESQ_W-1:0]          r_esq;
    logic [tsf_pkg::RHS_W-1:0]          r_rhs;

    tsf_pkg::t_uop                      cur_uop, r_uop1;
    logic                               r_mac_v;
    logic signed [tsf_pkg::OPND_W-1:0]  op_a, op_b;
    logic signed [tsf_pkg::PROD_W-1:0]  r_prod;
    logic signed [tsf_pkg::ACC_W-1:0]   r_acc, prod_ext, shifted, acc_sum;
    logic signed [tsf_pkg::MAG_W:0]     cr_raw, cr_abs;
    logic [tsf_pkg::MAG_W-1:0]          emax01;
    tsf_pkg::t_vertex                   out_v;

    function automatic logic signed [tsf_pkg::OPND_W-1:0] sx(
        input logic signed [tsf_pkg::DIFF_W-1:0] v);
        return {{(tsf_pkg::OPND_W - tsf_pkg::DIFF_W){v[tsf_pkg::DIFF_W-1]}}, v};
    endfunction

    function automatic logic signed [tsf_pkg::OPND_W-1:0] zx_half(
        input logic [tsf_pkg::HALF_W-1:0] v);
        return {{(tsf_pkg::OPND_W - tsf_pkg::HALF_W){1'b0}}, v};
    endfunction

    function automatic logic signed [tsf_pkg::OPND_W-1:0] pick(
        input tsf_pkg::t_src s,
        input logic signed [tsf_pkg::DIFF_W-1:0] u0, u1, u2, v0, v1, v2, w0, w1, w2,
        input logic [tsf_pkg::MAG_W-1:0] c0, c1, c2, em,
        input logic [tsf_pkg::ESQ_W-1:0] q,
        input logic [tsf_pkg::RATIO_W-1:0] ratio);
        logic signed [tsf_pkg::OPND_W-1:0] r;
        r = '0;
        case (s)
            tsf_pkg::S_UX:    r = sx(u0);
            tsf_pkg::S_UY:    r = sx(u1);
            tsf_pkg::S_UZ:    r = sx(u2);
            tsf_pkg::S_VX:    r = sx(v0);
            tsf_pkg::S_VY:    r = sx(v1);
            tsf_pkg::S_VZ:    r = sx(v2);
            tsf_pkg::S_WX:    r = sx(w0);
            tsf_pkg::S_WY:    r = sx(w1);
            tsf_pkg::S_WZ:    r = sx(w2);
            tsf_pkg::S_CXH:   r = zx_half(c0[tsf_pkg::MAG_W-1:tsf_pkg::HALF_W]);
            tsf_pkg::S_CXL:   r = zx_half(c0[tsf_pkg::HALF_W-1:0]);
            tsf_pkg::S_CYH:   r = zx_half(c1[tsf_pkg::MAG_W-1:tsf_pkg::HALF_W]);
            tsf_pkg::S_CYL:   r = zx_half(c1[tsf_pkg::HALF_W-1:0]);
            tsf_pkg::S_CZH:   r = zx_half(c2[tsf_pkg::MAG_W-1:tsf_pkg::HALF_W]);
            tsf_pkg::S_CZL:   r = zx_half(c2[tsf_pkg::HALF_W-1:0]);
            tsf_pkg::S_EH:    r = zx_half(em[tsf_pkg::MAG_W-1:tsf_pkg::HALF_W]);
            tsf_pkg::S_EL:    r = zx_half(em[tsf_pkg::HALF_W-1:0]);
            tsf_pkg::S_Q0:    r = {1'b0, q[tsf_pkg::CHUNK_W-1:0]};
            tsf_pkg::S_Q1:    r = {1'b0, q[2*tsf_pkg::CHUNK_W-1:tsf_pkg::CHUNK_W]};
            tsf_pkg::S_Q2:    r = {1'b0, q[3*tsf_pkg::CHUNK_W-1:2*tsf_pkg::CHUNK_W]};
            tsf_pkg::S_RATIO: r = {{(tsf_pkg::OPND_W - tsf_pkg::RATIO_W){1'b0}}, ratio};
            default:          r = '0;
        endcase
        return r;
    endfunction

    // Input word and configuration.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= '0;
        end else if (i_cfg_we) begin
            r_ratio <= i_cfg_data;
        end
    end

    // Vertex store.
    assign wr_data.x = r_in.pos_x;
    assign wr_data.y = r_in.pos_y;
    assign wr_data.z = r_in.pos_z;

    always_comb begin
        case (i_cmd.rd_sel)
            tsf_pkg::V_B: rd_addr = r_in.index_b;
            tsf_pkg::V_C: rd_addr = r_in.index_c;
            default:      rd_addr = r_in.index_a;
        endcase
    end

    tsf_vstore u_vstore (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_fill[tsf_pkg::VTX_AW-1:0]),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_slot <= i_cmd.rd_sel;
        end
        if (r_rd_pend) begin
            case (r_rd_slot)
                tsf_pkg::V_B: r_vb <= rd_data;
                tsf_pkg::V_C: r_vc <= rd_data;
                default:      r_va <= rd_data;
            endcase
        end
    end

    // Edge vectors: u = b - a, v = c - a, w = c - b.
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            r_du[0] <= {r_vb.x[19], r_vb.x} - {r_va.x[19], r_va.x};
            r_du[1] <= {r_vb.y[19], r_vb.y} - {r_va.y[19], r_va.y};
            r_du[2] <= {r_vb.z[19], r_vb.z} - {r_va.z[19], r_va.z};
            r_dv[0] <= {r_vc.x[19], r_vc.x} - {r_va.x[19], r_va.x};
            r_dv[1] <= {r_vc.y[19], r_vc.y} - {r_va.y[19], r_va.y};
            r_dv[2] <= {r_vc.z[19], r_vc.z} - {r_va.z[19], r_va.z};
            r_dw[0] <= {r_vc.x[19], r_vc.x} - {r_vb.x[19], r_vb.x};
            r_dw[1] <= {r_vc.y[19], r_vc.y} - {r_vb.y[19], r_vb.y};
            r_dw[2] <= {r_vc.z[19], r_vc.z} - {r_vb.z[19], r_vb.z};
        end
    end

    // Multiply stage.
    assign cur_uop = tsf_pkg::uop(i_cmd.step);
    assign op_a = pick(cur_uop.a, r_du[0], r_du[1], r_du[2], r_dv[0], r_dv[1], r_dv[2],
                       r_dw[0], r_dw[1], r_dw[2], r_cr[0], r_cr[1], r_cr[2], r_emax,
                       r_esq, r_ratio);
    assign op_b = pick(cur_uop.b, r_du[0], r_du[1], r_du[2], r_dv[0], r_dv[1], r_dv[2],
                       r_dw[0], r_dw[1], r_dw[2], r_cr[0], r_cr[1], r_cr[2], r_emax,
                       r_esq, r_ratio);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_v <= 1'b0;
        end else begin
            r_mac_v <= i_cmd.mac_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            r_prod <= op_a * op_b;
            r_uop1 <= cur_uop;
        end
    end

    // Accumulate stage.
    assign prod_ext = {{(tsf_pkg::ACC_W - tsf_pkg::PROD_W){r_prod[tsf_pkg::PROD_W-1]}},
                       r_prod};
    assign shifted  = prod_ext <<< r_uop1.shift;
    assign acc_sum  = r_uop1.neg ? (r_acc - shifted) : (r_acc + shifted);
    assign cr_raw   = acc_sum[tsf_pkg::MAG_W:0];
    assign cr_abs   = cr_raw[tsf_pkg::MAG_W] ? -cr_raw : cr_raw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            r_acc <= '0;
        end else if (r_mac_v) begin
            r_acc <= (r_uop1.dst == tsf_pkg::D_NONE) ? acc_sum : '0;
            case (r_uop1.dst)
                tsf_pkg::D_CX:   r_cr[0] <= cr_abs[tsf_pkg::MAG_W-1:0];
                tsf_pkg::D_CY:   r_cr[1] <= cr_abs[tsf_pkg::MAG_W-1:0];
                tsf_pkg::D_CZ:   r_cr[2] <= cr_abs[tsf_pkg::MAG_W-1:0];
                tsf_pkg::D_E0:   r_e[0]  <= acc_sum[tsf_pkg::MAG_W-1:0];
                tsf_pkg::D_E1:   r_e[1]  <= acc_sum[tsf_pkg::MAG_W-1:0];
                tsf_pkg::D_E2:   r_e[2]  <= acc_sum[tsf_pkg::MAG_W-1:0];
                tsf_pkg::D_AREA: r_area  <= acc_sum[tsf_pkg::AREA_W-1:0];
                tsf_pkg::D_ESQ:  r_esq   <= acc_sum[tsf_pkg::ESQ_W-1:0];
                tsf_pkg::D_RHS:  r_rhs   <= acc_sum[tsf_pkg::RHS_W-1:0];
                default: ;
            endcase
        end
    end

    // Longest edge, refreshed every cycle from the stored edges.
    assign emax01 = (r_e[1] > r_e[0]) ? r_e[1] : r_e[0];

    always_ff @(posedge i_clk) begin
        r_emax <= (r_e[2] > emax01) ? r_e[2] : emax01;
    end

    // Mesh counters.
    always_comb begin
        n_fill    = r_fill;
        n_emitted = r_emitted;
        n_seen    = r_seen;
        n_degen   = r_degen;
        n_thin    = r_thin;
        n_kept    = r_kept;
        n_error   = r_error;
        if (i_cmd.clear_mesh) begin
            n_fill    = '0;
            n_emitted = '0;
            n_seen    = '0;
            n_degen   = '0;
            n_thin    = '0;
            n_kept    = '0;
            n_error   = 1'b0;
        end else begin
            if (i_cmd.append) begin
                n_fill = r_fill + 1'b1;
            end
            if (i_cmd.inc_seen) begin
                n_seen = tsf_pkg::sat_inc(r_seen);
            end
            if (i_cmd.inc_degen) begin
                n_degen = tsf_pkg::sat_inc(r_degen);
            end
            if (i_cmd.inc_thin) begin
                n_thin = tsf_pkg::sat_inc(r_thin);
            end
            if (i_cmd.inc_kept) begin
                n_kept    = tsf_pkg::sat_inc(r_kept);
                n_emitted = r_emitted + tsf_pkg::EMIT_W'(3);
            end
            if (i_cmd.set_error) begin
                n_error = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_emitted <= '0;
            r_seen    <= '0;
            r_degen   <= '0;
            r_thin    <= '0;
            r_kept    <= '0;
            r_error   <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_emitted <= n_emitted;
            r_seen    <= n_seen;
            r_degen   <= n_degen;
            r_thin    <= n_thin;
            r_kept    <= n_kept;
            r_error   <= n_error;
        end
    end

    // Result register.
    always_comb begin
        case (i_cmd.out_vsel)
            tsf_pkg::V_A: out_v = r_va;
            tsf_pkg::V_B: out_v = r_vb;
            tsf_pkg::V_C: out_v = r_vc;
            default:      out_v = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status           <= i_cmd.out_status;
            r_out.out_x            <= out_v.x;
            r_out.out_y            <= out_v.y;
            r_out.out_z            <= out_v.z;
            r_out.run_last         <= i_cmd.out_last;
            r_out.triangles_seen   <= n_seen;
            r_out.degenerate_count <= n_degen;
            r_out.thin_count       <= n_thin;
            r_out.kept_count       <= n_kept;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status towards the controller.
    assign o_stat.op        = r_in.operation;
    assign o_stat.err       = r_error;
    assign o_stat.fill_full = (r_fill == tsf_pkg::FILL_W'(tsf_pkg::VTX_DEPTH));
    assign o_stat.idx_bad   = ({1'b0, r_in.index_a} >= r_fill) ||
                              ({1'b0, r_in.index_b} >= r_fill) ||
                              ({1'b0, r_in.index_c} >= r_fill);
    assign o_stat.room_ok   = ({1'b0, r_emitted} + (tsf_pkg::EMIT_W+1)'(3)) <=
                              (tsf_pkg::EMIT_W+1)'(tsf_pkg::MAX_OUT);
    assign o_stat.degen     = (r_emax == '0) || (r_area == '0);
    assign o_stat.thin      = {r_area, 16'd0} <= {4'd0, r_rhs};
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule
`default_nettype wire

// File: sv/tsf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_ctrl: sequencing state machine
// Decodes each word, steps the multiply-accumulate program and issues results.
// ----------------------------------------------------------------------------
module tsf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tsf_pkg::t_stat i_stat,
    output tsf_pkg::t_cmd       o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DISP   = 6'b000010,
        S_READ   = 6'b000100,
        S_CALC   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state                    r_state, n_state;
    logic [tsf_pkg::SEQ_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.step = r_cnt[tsf_pkg::STEP_W-1:0];
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.out_last = 1'b1;
                if (i_stat.op == tsf_pkg::OP_UNUSED) begin
                    n_state = S_IDLE;
                end else if (i_stat.op == tsf_pkg::OP_START) begin
                    if (i_stat.out_free) begin
                        o_cmd.clear_mesh = 1'b1;
                        o_cmd.load_out   = 1'b1;
                        o_cmd.out_status = tsf_pkg::ST_ACCEPTED;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.err) begin
                    if (i_stat.out_free) begin
                        o_cmd.load_out   = 1'b1;
                        o_cmd.out_status = tsf_pkg::ST_IGNORED;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.op == tsf_pkg::OP_APPEND) begin
                    if (i_stat.out_free) begin
                        o_cmd.load_out = 1'b1;
                        if (i_stat.fill_full) begin
                            o_cmd.set_error  = 1'b1;
                            o_cmd.out_status = tsf_pkg::ST_CAPACITY;
                        end else begin
                            o_cmd.append     = 1'b1;
                            o_cmd.out_status = tsf_pkg::ST_ACCEPTED;
                        end
                        n_state = S_IDLE;
                    end
                end else if (i_stat.idx_bad) begin
                    if (i_stat.out_free) begin
                        o_cmd.inc_seen   = 1'b1;
                        o_cmd.set_error  = 1'b1;
                        o_cmd.load_out   = 1'b1;
                        o_cmd.out_status = tsf_pkg::ST_BAD_INDEX;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.inc_seen = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = tsf_pkg::V_A;
                    n_cnt   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_cnt = r_cnt + 1'b1;
                case (r_cnt[1:0])
                    2'd0: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = tsf_pkg::V_B;
                    end
                    2'd1: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = tsf_pkg::V_C;
                    end
                    2'd3: begin
                        o_cmd.diff_en = 1'b1;
                        n_cnt   = '0;
                        n_state = S_CALC;
                    end
                    default: ;
                endcase
            end
            S_CALC: begin
                o_cmd.mac_en = (r_cnt <= tsf_pkg::SEQ_W'(tsf_pkg::LAST_STEP));
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == tsf_pkg::SEQ_W'(tsf_pkg::LAST_STEP + 1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state = S_IDLE;
                    if (i_stat.degen) begin
                        o_cmd.inc_degen  = 1'b1;
                        o_cmd.out_status = tsf_pkg::ST_DEGENERATE;
                    end else if (i_stat.thin) begin
                        o_cmd.inc_thin   = 1'b1;
                        o_cmd.out_status = tsf_pkg::ST_THIN;
                    end else if (!i_stat.room_ok) begin
                        o_cmd.set_error  = 1'b1;
                        o_cmd.out_status = tsf_pkg::ST_CAPACITY;
                    end else begin
                        o_cmd.inc_kept   = 1'b1;
                        o_cmd.out_status = tsf_pkg::ST_KEPT;
                        o_cmd.out_vsel   = tsf_pkg::V_A;
                        o_cmd.out_last   = 1'b0;
                        n_cnt   = '0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_status = tsf_pkg::ST_KEPT;
                    if (r_cnt[0]) begin
                        o_cmd.out_vsel = tsf_pkg::V_C;
                        o_cmd.out_last = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.out_vsel = tsf_pkg::V_B;
                    end
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// File: sv/triangle_sliver_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// A start, append or refused word is decoded in S_DISP, which loads its result once the
// result register is free; a checked triangle reads its vertices in S_READ, runs the program
// in S_CALC and loads its first result in S_DECIDE, and a kept one delivers its three vertex
// words on consecutive cycles when the consumer is ready. The block takes one word at a time;
// a triangle holds it through the 31-step program, whose 30 products pass in turn through one
// 29 x 29 multiplier. Reset is synchronous and active low; the vertex store is not cleared.
// ----------------------------------------------------------------------------
// triangle_sliver_filter: degenerate and thin triangle culling
// Builds a mesh vertex by vertex and checks each submitted triangle for
// zero area and for slivers against a programmable thinness ratio.
// ----------------------------------------------------------------------------
module triangle_sliver_filter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire tsf_pkg::t_in                 i_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output tsf_pkg::t_out                     o_out,
    input  wire logic                         i_cfg_we,
    input  wire logic [tsf_pkg::RATIO_W-1:0]  i_cfg_data
);

    // The controller and the datapath talk only through these two groups.
    tsf_pkg::t_cmd  cmd;
    tsf_pkg::t_stat stat;

    // The controller accepts a word only when it is idle. Each word is
    // decoded in the following cycle; a triangle then reads its three
    // vertices, runs the multiply-accumulate program and is judged.
    tsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the mesh state, the arithmetic and the result
    // register, so a finished result may wait while the next word enters.
    tsf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// File: sv/tsf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_checker: port level checks for the sliver filter
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module tsf_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire tsf_pkg::t_out o_out
);

    // A waiting result word keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    // Only kept vertices carry a position.
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != tsf_pkg::ST_KEPT) |->
        (o_out.out_x == '0) && (o_out.out_y == '0) && (o_out.out_z == '0))
        else $error("position on a word that is not a kept vertex");

    // Only the first two vertices of a kept triangle are not final.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.run_last |-> (o_out.status == tsf_pkg::ST_KEPT))
        else $error("non-final word that is not a kept vertex");

    // No outcome count may run ahead of the triangles seen.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.kept_count <= o_out.triangles_seen) &&
        (o_out.degenerate_count <= o_out.triangles_seen) &&
        (o_out.thin_count <= o_out.triangles_seen))
        else $error("outcome count exceeds triangles seen");

endmodule

bind triangle_sliver_filter tsf_checker u_tsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire

// File: tb/tb_triangle_sliver_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_sliver_filter: self-checking bench for the sliver filter
// Drives start, append and submit words with random idling on both sides,
// predicts every result word from an independent model of the mesh state and
// compares each field in order. The thinness ratio is changed between phases.
// ----------------------------------------------------------------------------
module tb_triangle_sliver_filter;

    localparam int RUN_LIMIT = 200000;
    localparam int ITEM_TOTAL = 280;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    tsf_pkg::t_in                in_word;
    logic                        out_valid;
    logic                        out_ready;
    tsf_pkg::t_out               out_word;
    logic                        cfg_we;
    logic [tsf_pkg::RATIO_W-1:0] cfg_data;

    // Predictor state: a private copy of the mesh and its counters.
    tsf_pkg::t_vertex            mesh_vtx [tsf_pkg::VTX_DEPTH];
    int unsigned                 mesh_fill;
    int unsigned                 mesh_emitted;
    logic [tsf_pkg::CNT_W-1:0]   n_seen, n_degen, n_thin, n_kept;
    logic                        mesh_err;
    logic [tsf_pkg::RATIO_W-1:0] ratio;

    tsf_pkg::t_out pending_results[$];
    tsf_pkg::t_out last_word;
    bit    failed;
    bit    quiet;       // no idling in the closing part of the run
    int    cycle_count;
    int    sent_count;

    triangle_sliver_filter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [tsf_pkg::CNT_W-1:0] bump(input logic [tsf_pkg::CNT_W-1:0] v);
        return (v == {tsf_pkg::CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic tsf_pkg::t_out make_result(input tsf_pkg::t_status st,
                                                  input tsf_pkg::t_vertex v,
                                                  input logic last);
        tsf_pkg::t_out r;
        r.status           = st;
        r.out_x            = v.x;
        r.out_y            = v.y;
        r.out_z            = v.z;
        r.run_last         = last;
        r.triangles_seen   = n_seen;
        r.degenerate_count = n_degen;
        r.thin_count       = n_thin;
        r.kept_count       = n_kept;
        return r;
    endfunction

    // Appends one expected word to the back of the queue.
    task automatic queue_result(input tsf_pkg::t_out r);
        pending_results.insert(pending_results.size(), r);
    endtask

    function automatic logic [63:0] edge_len_sq(input tsf_pkg::t_vertex p,
                                                input tsf_pkg::t_vertex q);
        longint dx, dy, dz;
        dx = longint'(q.x) - longint'(p.x);
        dy = longint'(q.y) - longint'(p.y);
        dz = longint'(q.z) - longint'(p.z);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // Works out the result words that one accepted word should cause and
    // queues them in order. The unused operation code produces nothing.
    task automatic predict_word(input tsf_pkg::t_in w);
        tsf_pkg::t_vertex zero_v, a, b, c;
        logic [63:0] e, e1, e2;
        longint ux, uy, uz, vx, vy, vz;
        logic signed [127:0] cx, cy, cz;
        logic [127:0] area, lhs, rhs, esq;
        zero_v = '0;
        case (tsf_pkg::t_op_code'(w.operation))
            tsf_pkg::OP_START: begin
                mesh_fill = 0; mesh_emitted = 0;
                n_seen = '0; n_degen = '0; n_thin = '0; n_kept = '0;
                mesh_err = 1'b0;
                queue_result(make_result(tsf_pkg::ST_ACCEPTED, zero_v, 1'b1));
            end
            tsf_pkg::OP_UNUSED: ;
            default: begin
                if (mesh_err) begin
                    queue_result(make_result(tsf_pkg::ST_IGNORED, zero_v, 1'b1));
                end else if (tsf_pkg::t_op_code'(w.operation) == tsf_pkg::OP_APPEND) begin
                    if (mesh_fill >= tsf_pkg::VTX_DEPTH) begin
                        mesh_err = 1'b1;
                        queue_result(make_result(tsf_pkg::ST_CAPACITY, zero_v, 1'b1));
                    end else begin
                        mesh_vtx[mesh_fill] = '{w.pos_x, w.pos_y, w.pos_z};
                        mesh_fill++;
                        queue_result(make_result(tsf_pkg::ST_ACCEPTED, zero_v, 1'b1));
                    end
                end else begin
                    n_seen = bump(n_seen);
                    if (w.index_a >= mesh_fill || w.index_b >= mesh_fill
                            || w.index_c >= mesh_fill) begin
                        mesh_err = 1'b1;
                        queue_result(make_result(tsf_pkg::ST_BAD_INDEX, zero_v, 1'b1));
                    end else begin
                        a = mesh_vtx[w.index_a];
                        b = mesh_vtx[w.index_b];
                        c = mesh_vtx[w.index_c];
                        e  = edge_len_sq(a, b);
                        e1 = edge_len_sq(b, c);
                        e2 = edge_len_sq(c, a);
                        if (e1 > e) e = e1;
                        if (e2 > e) e = e2;
                        ux = longint'(b.x) - a.x; uy = longint'(b.y) - a.y;
                        uz = longint'(b.z) - a.z;
                        vx = longint'(c.x) - a.x; vy = longint'(c.y) - a.y;
                        vz = longint'(c.z) - a.z;
                        cx = uy * vz - uz * vy;
                        cy = uz * vx - ux * vz;
                        cz = ux * vy - uy * vx;
                        area = cx * cx + cy * cy + cz * cz;
                        // The bound is taken modulo 2^128 here; the design keeps it in 100 bits for the wide compare.
                        lhs = area << 16;
                        esq = 128'(e) * 128'(e);
                        rhs = esq * 128'(ratio);
                        if (e == 0 || area == 0) begin
                            n_degen = bump(n_degen);
                            queue_result(make_result(tsf_pkg::ST_DEGENERATE, zero_v, 1'b1));
                        end else if (lhs <= rhs) begin
                            n_thin = bump(n_thin);
                            queue_result(make_result(tsf_pkg::ST_THIN, zero_v, 1'b1));
                        end else if (mesh_emitted + 3 > tsf_pkg::MAX_OUT) begin
                            mesh_err = 1'b1;
                            queue_result(make_result(tsf_pkg::ST_CAPACITY, zero_v, 1'b1));
                        end else begin
                            mesh_emitted += 3;
                            n_kept = bump(n_kept);
                            queue_result(make_result(tsf_pkg::ST_KEPT, a, 1'b0));
                            queue_result(make_result(tsf_pkg::ST_KEPT, b, 1'b0));
                            queue_result(make_result(tsf_pkg::ST_KEPT, c, 1'b1));
                        end
                    end
                end
            end
        endcase
    endtask

    // Sends one word, with an optional burst of idling beforehand. The word
    // is predicted at the edge on which it is taken. Valid stays high after
    // the edge so that the next word may follow without a gap.
    task automatic send_word(input tsf_pkg::t_in w);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_word(w);
        sent_count++;
    endtask

    // Result checker and consumer-side stalls.
    int stall_left;
    always @(posedge clk) begin
        tsf_pkg::t_out exp_r;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready) begin
            last_word = out_word;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %p",
                         $time, out_word);
                failed = 1'b1;
            end else begin
                exp_r = pending_results.pop_front();
                if (out_word !== exp_r) begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, exp_r, out_word);
                    failed = 1'b1;
                end
            end
        end
        if (quiet) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 7);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (cycle_count > RUN_LIMIT) begin
                $display("[triangle_sliver_filter] ERROR");
                $finish;
            end
        end
    end

    // Waits until every predicted word has come back, then lets a triangle's
    // worth of cycles pass so that the block is idle before a register write.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_ratio(input logic [tsf_pkg::RATIO_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        ratio = v;
    endtask

    function automatic tsf_pkg::t_in op_word(input tsf_pkg::t_op_code op);
        tsf_pkg::t_in w;
        w = '0;
        w.operation = op;
        return w;
    endfunction

    function automatic tsf_pkg::t_in vtx_word(input int x, input int y, input int z);
        tsf_pkg::t_in w;
        w = op_word(tsf_pkg::OP_APPEND);
        w.pos_x = tsf_pkg::COORD_W'(x);
        w.pos_y = tsf_pkg::COORD_W'(y);
        w.pos_z = tsf_pkg::COORD_W'(z);
        w.index_a = tsf_pkg::VTX_AW'($urandom);
        w.index_b = tsf_pkg::VTX_AW'($urandom);
        w.index_c = tsf_pkg::VTX_AW'($urandom);
        return w;
    endfunction

    function automatic tsf_pkg::t_in tri_word(input int ia, input int ib, input int ic);
        tsf_pkg::t_in w;
        w = op_word(tsf_pkg::OP_SUBMIT);
        w.pos_x = tsf_pkg::COORD_W'($urandom);
        w.pos_y = tsf_pkg::COORD_W'($urandom);
        w.pos_z = tsf_pkg::COORD_W'($urandom);
        w.index_a = tsf_pkg::VTX_AW'(ia);
        w.index_b = tsf_pkg::VTX_AW'(ib);
        w.index_c = tsf_pkg::VTX_AW'(ic);
        return w;
    endfunction

    // A coordinate, mostly small so that thin and kept cases both occur.
    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 524287 : -524288;
            1:       return int'($urandom) >>> 12;
            default: return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // Directed rows: the word to send and, where obvious, the status it gives.
    typedef struct {
        tsf_pkg::t_in     w;
        bit               has_status;
        tsf_pkg::t_status status;
    } t_row;

    t_row directed_rows[$];

    task automatic add_row(input tsf_pkg::t_in w, input bit has_st,
                           input tsf_pkg::t_status st);
        t_row r;
        r.w = w; r.has_status = has_st; r.status = st;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    initial begin
        int n_mesh, kind, n_vtx, n_tri;
        tsf_pkg::t_in w;
        rst_n = 1'b0; in_valid = 1'b0; in_word = '0; out_ready = 1'b0;
        cfg_we = 1'b0; cfg_data = '0; failed = 1'b0; quiet = 1'b0;
        cycle_count = 0; stall_left = 0; sent_count = 0; last_word = '0;
        mesh_fill = 0; mesh_emitted = 0; mesh_err = 1'b0; ratio = '0;
        n_seen = '0; n_degen = '0; n_thin = '0; n_kept = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        add_row(op_word(tsf_pkg::OP_START), 1, tsf_pkg::ST_ACCEPTED);
        add_row(vtx_word(524287, -524288, 0), 1, tsf_pkg::ST_ACCEPTED);
        add_row(vtx_word(-524288, 524287, 524287), 1, tsf_pkg::ST_ACCEPTED);
        add_row(vtx_word(0, 0, -524288), 1, tsf_pkg::ST_ACCEPTED);
        add_row(vtx_word(0, 0, 0), 1, tsf_pkg::ST_ACCEPTED);
        add_row(vtx_word(256, 0, 0), 1, tsf_pkg::ST_ACCEPTED);
        add_row(vtx_word(0, 256, 0), 1, tsf_pkg::ST_ACCEPTED);
        add_row(vtx_word(512, 0, 0), 1, tsf_pkg::ST_ACCEPTED);
        add_row(tri_word(0, 1, 2), 0, tsf_pkg::ST_KEPT);         // extreme coordinates
        add_row(tri_word(3, 3, 3), 1, tsf_pkg::ST_DEGENERATE);   // a single point
        add_row(tri_word(3, 4, 6), 1, tsf_pkg::ST_DEGENERATE);   // collinear
        add_row(tri_word(3, 4, 5), 0, tsf_pkg::ST_KEPT);
        add_row(op_word(tsf_pkg::OP_UNUSED), 0, tsf_pkg::ST_ACCEPTED);
        add_row(tri_word(3, 4, 7), 1, tsf_pkg::ST_BAD_INDEX);    // index past the fill
        add_row(vtx_word(1, 1, 1), 1, tsf_pkg::ST_IGNORED);
        add_row(tri_word(0, 1, 2), 1, tsf_pkg::ST_IGNORED);
        add_row(op_word(tsf_pkg::OP_START), 1, tsf_pkg::ST_ACCEPTED);
        add_row(tri_word(1023, 1023, 1023), 1, tsf_pkg::ST_BAD_INDEX);
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].w);
            if (directed_rows[i].has_status) begin
                drain();
                if (last_word.status !== directed_rows[i].status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, directed_rows[i].status, last_word.status);
                    failed = 1'b1;
                end
            end
        end

        // Thin versus kept at the ratio extremes: a long sliver.
        write_ratio(16'hFFFF);
        send_word(op_word(tsf_pkg::OP_START));
        send_word(vtx_word(0, 0, 0));
        send_word(vtx_word(100000, 0, 0));
        send_word(vtx_word(50000, 1, 0));
        send_word(tri_word(0, 1, 2));
        send_word(vtx_word(0, 100000, 0));
        send_word(tri_word(0, 1, 3));
        write_ratio(16'h0000);
        send_word(tri_word(0, 1, 2));

        // Random part: meshes of well-formed work with some noise.
        n_mesh = 0;
        while (sent_count < ITEM_TOTAL) begin
            if (n_mesh % 3 == 0) write_ratio(tsf_pkg::RATIO_W'($urandom));
            else if (n_mesh == 4) write_ratio(16'd1);
            if (sent_count > ITEM_TOTAL - 60) quiet = 1'b1;
            send_word(op_word(tsf_pkg::OP_START));
            n_vtx = $urandom_range(3, 10);
            n_tri = $urandom_range(5, 25);
            for (int v = 0; v < n_vtx; v++)
                send_word(vtx_word(rand_coord(), rand_coord(), rand_coord()));
            for (int t = 0; t < n_tri; t++) begin
                kind = $urandom_range(0, 19);
                if (kind == 0) w = tri_word($urandom, $urandom, $urandom);
                else if (kind == 1) w = op_word(tsf_pkg::OP_UNUSED);
                else if (kind == 2)
                    w = vtx_word(rand_coord(), rand_coord(), rand_coord());
                else w = tri_word($urandom_range(0, mesh_fill - 1),
                                  $urandom_range(0, mesh_fill - 1),
                                  $urandom_range(0, mesh_fill - 1));
                if (w.operation == tsf_pkg::OP_UNUSED)
                    w.pos_x = tsf_pkg::COORD_W'($urandom);
                send_word(w);
            end
            n_mesh++;
        end

        drain();
        if (!failed)
            $display("[triangle_sliver_filter] OK");
        else
            $display("[triangle_sliver_filter] ERROR");
        $finish;
    end

endmodule
